// ===== hw/rtl/bcpf_pkg.sv =====
// shared types, codes and pair test functions for the box collision pair finder
package bcpf_pkg;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_SCAN   = 2'd3;

  // result status codes
  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_PAIR = 2'd2;

  localparam int MASK_REGS = 4;
  localparam int MASK_W    = 64;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [3:0]         box_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot_a;
    logic [2:0] slot_b;
    logic       last;
  } out_item_t;

  // geometry of one stored box
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } geom_t;

  // one stored box as read back from the table
  typedef struct packed {
    geom_t      geom;
    logic [3:0] typ;
  } box_t;

  // write strobes into the box table
  typedef struct packed {
    logic geom_en;
    logic type_en;
  } tbl_wr_ctl_t;

  typedef logic [MASK_REGS-1:0][MASK_W-1:0] mask_set_t;

  // mask bit for the ordered type pair
  function automatic logic pair_allowed(input mask_set_t mask, input logic [3:0] ta,
                                        input logic [3:0] tb);
    logic [5:0] bit_idx;
    bit_idx = {ta[1:0], tb};
    return mask[ta[3:2]][bit_idx];
  endfunction

  // strict overlap of the open rectangles
  function automatic logic box_overlap(input geom_t a, input geom_t b);
    logic signed [16:0] ax, ay, bx, by;
    logic signed [16:0] ax_end, ay_end, bx_end, by_end;
    ax = {a.x[15], a.x};
    ay = {a.y[15], a.y};
    bx = {b.x[15], b.x};
    by = {b.y[15], b.y};
    ax_end = ax + $signed({2'b00, a.w});
    ay_end = ay + $signed({2'b00, a.h});
    bx_end = bx + $signed({2'b00, b.w});
    by_end = by + $signed({2'b00, b.h});
    return (ax < bx_end) && (bx < ax_end) && (ay < by_end) && (by < ay_end);
  endfunction

endpackage

// ===== hw/rtl/bcpf_box_mem.sv =====
// box table: geometry and type memories, one write port and two registered read ports
module bcpf_box_mem #(
  parameter int SLOTS  = 8,
  parameter int SLOT_W = 3
) (
  input  logic                 clk,
  input  bcpf_pkg::tbl_wr_ctl_t wr_ctl,
  input  logic [SLOT_W-1:0]    wr_idx,
  input  bcpf_pkg::geom_t      wr_geom,
  input  logic [3:0]           wr_type,
  input  logic                 rd_en,
  input  logic [SLOT_W-1:0]    rd_a_idx,
  input  logic [SLOT_W-1:0]    rd_b_idx,
  output bcpf_pkg::box_t       rd_a,
  output bcpf_pkg::box_t       rd_b
);
  import bcpf_pkg::*;

  geom_t      geom_mem [SLOTS];
  logic [3:0] type_mem [SLOTS];

  // write port, type kept on update
  always_ff @(posedge clk) begin
    if (wr_ctl.geom_en) begin
      geom_mem[wr_idx] <= wr_geom;
    end
    if (wr_ctl.type_en) begin
      type_mem[wr_idx] <= wr_type;
    end
  end

  // two read ports with registered data, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a.geom <= geom_mem[rd_a_idx];
      rd_a.typ  <= type_mem[rd_a_idx];
      rd_b.geom <= geom_mem[rd_b_idx];
      rd_b.typ  <= type_mem[rd_b_idx];
    end
  end

endmodule

// ===== hw/rtl/box_collision_pair_finder_top.sv =====
// top level of the box collision pair finder: request sequencer, scan pipeline, result register
//
// Usage. Requests arrive on in_valid/in_stall/in_data; one transfer happens when
// in_valid is high and in_stall is low. Results leave on out_valid/out_stall/out_data
// from an output register, in the same way. The four pair mask registers are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// writes are expected only while no request is in flight.
// Add, update and remove finish in the cycle of their transfer: the single result
// is in the output register in the next cycle and the next request can be taken
// in that same cycle if the output register is free or being drained.
// A scan walks all SLOTS*(SLOTS-1)/2 slot pairs, one pair per cycle while the pipeline
// is not frozen, through a two-stage pipeline around the box table memory (read, then
// test), then flushes the held last pair in ST_FLUSH; the pair rate is limited by the
// table's two read ports. The last result of a scan carries last=1, which is why one
// hit is held back until the next is known.
// When the receiver stalls, the scan pipeline freezes once a second hit waits
// for the output register; nothing is lost or repeated. in_stall is high while a
// scan runs or while a stalled result still fills the output register.
// Reset empties the table (all slots free) and clears the masks; no clearing
// pass is needed since box data is only used from slots that an add has written.
module box_collision_pair_finder_top #(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bcpf_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bcpf_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data
);
  import bcpf_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W  = ((SLOT_W > 3) ? SLOT_W : 3) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // slot index to the 3-bit result field
  function automatic logic [2:0] to_slot3(input logic [SLOT_W-1:0] idx);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(idx);
    return wide[2:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  mask_set_t          mask_r, mask_nxt;
  logic [SLOT_W-1:0]  i_r, i_nxt, k_r, k_nxt;
  logic               a_done_r, a_done_nxt;
  logic               s1_live_r, s1_live_nxt;
  logic               s1_pv_r, s1_pv_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic [SLOT_W-1:0]  s1_i_r, s1_i_nxt, s1_k_r, s1_k_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]  pend_i_r, pend_i_nxt, pend_k_r, pend_k_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  tbl_wr_ctl_t        wr_ctl;
  logic [SLOT_W-1:0]  wr_idx;
  geom_t              wr_geom;
  logic               rd_en;
  box_t               rd_a, rd_b;

  logic               in_acc;
  logic               out_free;
  logic               hit;
  logic               adv;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic [CMP_W-1:0]   slot_ext;
  logic               slot_ok;
  logic [SLOT_W-1:0]  slot_idx;

  bcpf_box_mem #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_box_mem (
    .clk      (clk),
    .wr_ctl   (wr_ctl),
    .wr_idx   (wr_idx),
    .wr_geom  (wr_geom),
    .wr_type  (in_data.box_type),
    .rd_en    (rd_en),
    .rd_a_idx (i_r),
    .rd_b_idx (k_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  // handshake status
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // request slot range check
  assign slot_ext = CMP_W'(in_data.slot);
  assign slot_ok  = slot_ext < CMP_W'(SLOTS);
  assign slot_idx = slot_ext[SLOT_W-1:0];

  assign wr_geom.x = in_data.pos_x;
  assign wr_geom.y = in_data.pos_y;
  assign wr_geom.w = in_data.box_width;
  assign wr_geom.h = in_data.box_height;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!valid_r[j]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(j);
      end
    end
  end

  // pair test on the registered table data
  assign hit = s1_live_r && s1_pv_r && pair_allowed(mask_r, rd_a.typ, rd_b.typ) &&
               box_overlap(rd_a.geom, rd_b.geom);

  // pipeline freezes only when a second hit needs the busy output register
  assign adv = !(hit && pend_v_r) || out_free;

  // next state
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    mask_nxt      = mask_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    a_done_nxt    = a_done_r;
    s1_live_nxt   = s1_live_r;
    s1_pv_nxt     = s1_pv_r;
    s1_last_nxt   = s1_last_r;
    s1_i_nxt      = s1_i_r;
    s1_k_nxt      = s1_k_r;
    pend_v_nxt    = pend_v_r;
    pend_i_nxt    = pend_i_r;
    pend_k_nxt    = pend_k_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_ctl        = '0;
    wr_idx        = slot_idx;
    rd_en         = 1'b0;

    // result transfer empties the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // mask register writes
    if (cfg_valid) begin
      mask_nxt[cfg_index] = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = STS_DONE;
          out_nxt.slot_a = in_data.slot;
          out_nxt.slot_b = 3'd0;
          out_nxt.last   = 1'b1;
          case (in_data.req_type)
            REQ_ADD: begin
              if (free_found) begin
                wr_ctl.geom_en      = 1'b1;
                wr_ctl.type_en      = 1'b1;
                wr_idx              = free_idx;
                valid_nxt[free_idx] = 1'b1;
                out_nxt.slot_a      = to_slot3(free_idx);
              end else begin
                out_nxt.status = STS_FULL;
                out_nxt.slot_a = 3'd0;
              end
            end
            REQ_UPDATE: begin
              if (slot_ok && valid_r[slot_idx]) begin
                wr_ctl.geom_en = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (slot_ok) begin
                valid_nxt[slot_idx] = 1'b0;
              end
            end
            REQ_SCAN: begin
              out_valid_nxt = out_valid_r && out_stall;
              state_nxt     = ST_SCAN;
              i_nxt         = '0;
              k_nxt         = SLOT_W'(1);
              a_done_nxt    = 1'b0;
              s1_live_nxt   = 1'b0;
              pend_v_nxt    = 1'b0;
            end
            default: begin
              out_valid_nxt = out_valid_r && out_stall;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // test stage: hold the newest hit, release the one before it
          if (s1_live_r) begin
            if (hit) begin
              if (pend_v_r) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STS_PAIR;
                out_nxt.slot_a = to_slot3(pend_i_r);
                out_nxt.slot_b = to_slot3(pend_k_r);
                out_nxt.last   = 1'b0;
              end
              pend_v_nxt = 1'b1;
              pend_i_nxt = s1_i_r;
              pend_k_nxt = s1_k_r;
            end
            if (s1_last_r) begin
              state_nxt = ST_FLUSH;
            end
          end
          // read stage: issue the next pair
          s1_live_nxt = !a_done_r;
          if (!a_done_r) begin
            rd_en       = 1'b1;
            s1_pv_nxt   = valid_r[i_r] && valid_r[k_r];
            s1_i_nxt    = i_r;
            s1_k_nxt    = k_r;
            s1_last_nxt = (i_r == SLOT_W'(SLOTS - 2));
            if (k_r == SLOT_W'(SLOTS - 1)) begin
              if (i_r == SLOT_W'(SLOTS - 2)) begin
                a_done_nxt = 1'b1;
              end
              i_nxt = i_r + SLOT_W'(1);
              k_nxt = i_r + SLOT_W'(2);
            end else begin
              k_nxt = k_r + SLOT_W'(1);
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.last  = 1'b1;
          if (pend_v_r) begin
            out_nxt.status = STS_PAIR;
            out_nxt.slot_a = to_slot3(pend_i_r);
            out_nxt.slot_b = to_slot3(pend_k_r);
          end else begin
            out_nxt.status = STS_DONE;
            out_nxt.slot_a = 3'd0;
            out_nxt.slot_b = 3'd0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      mask_r      <= '0;
      a_done_r    <= 1'b1;
      s1_live_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      mask_r      <= mask_nxt;
      a_done_r    <= a_done_nxt;
      s1_live_r   <= s1_live_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    s1_pv_r   <= s1_pv_nxt;
    s1_last_r <= s1_last_nxt;
    s1_i_r    <= s1_i_nxt;
    s1_k_r    <= s1_k_nxt;
    pend_i_r  <= pend_i_nxt;
    pend_k_r  <= pend_k_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== dv/box_collision_pair_finder_checker.sv =====
// checker for the box collision pair finder: box table copy, result prediction and compare
module box_collision_pair_finder_checker #(
  parameter int SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  bcpf_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  bcpf_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   answers_due,
  output int                   fail_count
);
  import bcpf_pkg::*;

  localparam int PAIR_LIMIT = SLOTS * (SLOTS - 1) / 2;

  // own copy of the masks and the box table
  mask_set_t  type_masks;
  logic [SLOTS-1:0] box_used;
  geom_t      box_geom [SLOTS];
  logic [3:0] box_kind [SLOTS];

  // results still owed by the block, oldest first
  out_item_t  table_answers [$];
  out_item_t  want;
  int         errs = 0;

  // mask bit for the ordered type pair (first, second)
  function automatic bit pair_enabled(input logic [3:0] first, input logic [3:0] second);
    int bit_pos;
    bit_pos = int'(first[1:0]) * 16 + int'(second);
    return type_masks[first[3:2]][bit_pos];
  endfunction

  // open rectangles intersect, edges that only touch do not count
  function automatic bit boxes_cross(input geom_t a, input geom_t b);
    int ax, ay, bx, by, aw, ah, bw, bh;
    ax = int'(a.x);
    ay = int'(a.y);
    bx = int'(b.x);
    by = int'(b.y);
    aw = int'(a.w);
    ah = int'(a.h);
    bw = int'(b.w);
    bh = int'(b.h);
    return (ax < bx + bw) && (bx < ax + aw) && (ay < by + bh) && (by < ay + ah);
  endfunction

  function automatic geom_t geom_of(input in_item_t rq);
    geom_t g;
    g.x = rq.pos_x;
    g.y = rq.pos_y;
    g.w = rq.box_width;
    g.h = rq.box_height;
    return g;
  endfunction

  // result fields as text for messages
  function automatic string item_text(input out_item_t r);
    return $sformatf("status=%0d slot_a=%0d slot_b=%0d last=%0d",
                     r.status, r.slot_a, r.slot_b, r.last);
  endfunction

  // apply one request to the table copy and queue the results it owes
  task automatic run_table_request(input in_item_t rq);
    out_item_t ack;
    out_item_t hit;
    int        free_slot;
    int        hits;
    logic      have_hit;
    ack = '0;
    ack.status = STS_DONE;
    ack.last = 1'b1;
    case (rq.req_type)
      REQ_ADD: begin
        free_slot = -1;
        for (int s = SLOTS - 1; s >= 0; s--) if (!box_used[s]) free_slot = s;
        if (free_slot < 0) begin
          ack.status = STS_FULL;
        end else begin
          box_used[free_slot] = 1'b1;
          box_geom[free_slot] = geom_of(rq);
          box_kind[free_slot] = rq.box_type;
          ack.slot_a = 3'(free_slot);
        end
        table_answers.push_back(ack);
      end
      REQ_UPDATE: begin
        // type is kept, a free slot is left alone
        if (int'(rq.slot) < SLOTS && box_used[rq.slot]) box_geom[rq.slot] = geom_of(rq);
        ack.slot_a = rq.slot;
        table_answers.push_back(ack);
      end
      REQ_REMOVE: begin
        if (int'(rq.slot) < SLOTS) box_used[rq.slot] = 1'b0;
        ack.slot_a = rq.slot;
        table_answers.push_back(ack);
      end
      default: begin
        // scan: hold one hit back so the final one can carry last
        hits = 0;
        have_hit = 1'b0;
        hit = '0;
        for (int i = 0; i < SLOTS; i++) begin
          for (int k = i + 1; k < SLOTS; k++) begin
            if (box_used[i] && box_used[k] && hits < PAIR_LIMIT &&
                pair_enabled(box_kind[i], box_kind[k]) &&
                boxes_cross(box_geom[i], box_geom[k])) begin
              if (have_hit) table_answers.push_back(hit);
              hit.status = STS_PAIR;
              hit.slot_a = 3'(i);
              hit.slot_b = 3'(k);
              hit.last = 1'b0;
              have_hit = 1'b1;
              hits++;
            end
          end
        end
        if (have_hit) begin
          hit.last = 1'b1;
          table_answers.push_back(hit);
        end else begin
          table_answers.push_back(ack);
        end
      end
    endcase
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      type_masks = '0;
      box_used = '0;
      table_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) type_masks[cfg_index] = cfg_data;
      if (out_valid && !out_stall) begin
        if (table_answers.size() == 0) begin
          errs++;
          $display("%0t: result transfer with nothing expected: expected none, got %s",
                   $time, item_text(out_data));
        end else begin
          want = table_answers.pop_front();
          if (out_data !== want) begin
            errs++;
            $display("%0t: result mismatch: expected %s, got %s",
                     $time, item_text(want), item_text(out_data));
          end
        end
      end
      if (in_valid && !in_stall) run_table_request(in_data);
    end
    answers_due <= table_answers.size();
    fail_count <= errs;
  end

endmodule

// ===== dv/box_collision_pair_finder_top_tb.sv =====
// testbench top for the box collision pair finder: clock, reset, stimulus and verdict
module box_collision_pair_finder_top_tb;
  import bcpf_pkg::*;

  localparam int SLOTS         = 8;
  localparam int ITEMS         = 480;
  localparam int PHASES        = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_CYCLES    = 3_000_000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_ready;
  int          answers_due;
  int          fail_count;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_ask = 0;
  int          hold_seen = 0;
  int          hold_count = 0;
  mask_set_t   mask_plan;

  box_collision_pair_finder_top #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  box_collision_pair_finder_checker #(.SLOTS(SLOTS)) pair_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .answers_due (answers_due),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop
  initial begin
    #(20 * RUN_CYCLES);
    $display("box_collision_pair_finder_top_tb NOT OK");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t box_req(input logic [1:0] kind, input int slot, input int x,
                                       input int y, input int w, input int h, input int t);
    in_item_t rq;
    rq.req_type = kind;
    rq.slot = 3'(slot);
    rq.pos_x = 16'(x);
    rq.pos_y = 16'(y);
    rq.box_width = 15'(w);
    rq.box_height = 15'(h);
    rq.box_type = 4'(t);
    return rq;
  endfunction

  // mostly boxes in a small area so that pairs collide, now and then anything at all
  function automatic in_item_t random_request();
    in_item_t rq;
    int pick;
    pick = $urandom_range(99);
    rq.req_type = (pick < 32) ? REQ_ADD : (pick < 52) ? REQ_UPDATE :
                  (pick < 72) ? REQ_REMOVE : REQ_SCAN;
    rq.slot = 3'($urandom_range(7));
    rq.box_type = 4'($urandom_range(15));
    if ($urandom_range(9) == 0) begin
      rq.pos_x = 16'($urandom);
      rq.pos_y = 16'($urandom);
      rq.box_width = 15'($urandom);
      rq.box_height = 15'($urandom);
    end else begin
      rq.pos_x = 16'($urandom_range(160)) - 16'd80;
      rq.pos_y = 16'($urandom_range(160)) - 16'd80;
      rq.box_width = 15'($urandom_range(70));
      rq.box_height = 15'($urandom_range(70));
      if ($urandom_range(19) == 0) rq.box_width = '0;
      if ($urandom_range(19) == 0) rq.box_height = '0;
    end
    return rq;
  endfunction

  // one request transfer, with a random gap in front of it
  task automatic offer_request(input in_item_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every owed result, then a little more
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input int idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_masks(input mask_set_t m);
    for (int r = 0; r < MASK_REGS; r++) write_mask(r, m[r]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, free slots, extremes, touching edges, zero sizes
    offer_request(box_req(REQ_SCAN, 0, 0, 0, 0, 0, 0));
    offer_request(box_req(REQ_UPDATE, 3, 5, 5, 5, 5, 0));
    offer_request(box_req(REQ_REMOVE, 5, 0, 0, 0, 0, 0));
    offer_request(box_req(REQ_ADD, 7, -32768, -32768, 32767, 32767, 0));
    offer_request(box_req(REQ_ADD, 0, -100, -100, 200, 200, 1));
    offer_request(box_req(REQ_ADD, 0, 100, -100, 50, 50, 2));
    offer_request(box_req(REQ_ADD, 0, 0, 0, 0, 40, 3));
    offer_request(box_req(REQ_ADD, 0, 0, 0, 40, 0, 4));
    offer_request(box_req(REQ_ADD, 0, 32767, 32767, 32767, 32767, 15));
    offer_request(box_req(REQ_ADD, 0, 32760, 32760, 10, 10, 14));
    offer_request(box_req(REQ_ADD, 0, -50, -50, 100, 100, 7));
    // table full
    offer_request(box_req(REQ_ADD, 0, 1, 1, 1, 1, 12));
    // masks still clear after reset
    offer_request(box_req(REQ_SCAN, 0, 0, 0, 0, 0, 0));

    settle();
    mask_plan = '1;
    load_masks(mask_plan);
    offer_request(box_req(REQ_SCAN, 0, 0, 0, 0, 0, 0));

    // only (1,7) and (15,14) allowed: order of the types matters
    settle();
    mask_plan = '0;
    mask_plan[0][23] = 1'b1;
    mask_plan[3][62] = 1'b1;
    load_masks(mask_plan);
    offer_request(box_req(REQ_SCAN, 0, 0, 0, 0, 0, 0));
    offer_request(box_req(REQ_REMOVE, 2, 0, 0, 0, 0, 0));
    offer_request(box_req(REQ_ADD, 0, 0, 0, 10, 10, 9));

    // every pair collides: the most results one scan can give
    settle();
    mask_plan = '1;
    load_masks(mask_plan);
    for (int s = 0; s < SLOTS; s++)
      if (s != 2) offer_request(box_req(REQ_UPDATE, s, 2, 2, 5, 5, 0));
    offer_request(box_req(REQ_SCAN, 0, 0, 0, 0, 0, 0));

    // random phases, each with its own masks and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      for (int r = 0; r < MASK_REGS; r++) begin
        case (ph)
          0: mask_plan[r] = '1;
          1: mask_plan[r] = {$urandom, $urandom};
          2: mask_plan[r] = r[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
          default: mask_plan[r] = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
      end
      load_masks(mask_plan);
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 88;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct <= 8;
        end
      endcase
      for (int n = 0; n < ITEMS / PHASES; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && n == 30) hold_ask <= hold_ask + 1;
        // sender waits for the block to empty
        if (ph == 1 && n == 60) settle();
        offer_request(random_request());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("box_collision_pair_finder_top_tb OK");
    end else begin
      $display("box_collision_pair_finder_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bcpf_pkg.sv
hw/rtl/bcpf_box_mem.sv
hw/rtl/box_collision_pair_finder_top.sv
dv/box_collision_pair_finder_checker.sv
dv/box_collision_pair_finder_top_tb.sv
